// File: rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks (the top level includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked implication or property, disabled while reset is high.
`define STP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Condition that must never hold at a clock edge outside reset.
`define STP_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define STP_ASSERT(label, clk, rst, prop)
`define STP_NEVER(label, clk, rst, cond)
`endif
`endif

// File: rtl/stp_pkg.sv
// Shared types and constants of the stepper sweep light peak tracker.
package stp_pkg;

   localparam int ADC_BITS_DEFAULT = 10;
   localparam int LEVEL_W          = 17;
   localparam int POS_W            = 8;
   localparam int LIMIT_W          = 7;
   localparam int PHASE_W          = 4;
   localparam int LEVEL_SCALE      = 100;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd50;
   localparam logic [POS_W-1:0]   POS_RESET   = 8'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic load;     // capture item, preload dividend
      logic shift;    // one restoring division step
      logic commit;   // update tracker state, load result register
   } dp_cmd_type;

   typedef struct packed {
      logic div_last; // current step is the final quotient bit
   } dp_status_type;

   // One-hot coil drive for the low two position bits.
   function automatic logic [PHASE_W-1:0] phase_of(input logic [1:0] sel);
      logic [PHASE_W-1:0] ph;
      case (sel)
         2'd0:    ph = 4'd1;
         2'd1:    ph = 4'd2;
         2'd2:    ph = 4'd4;
         2'd3:    ph = 4'd8;
         default: ph = 4'd1;
      endcase
      return ph;
   endfunction

endpackage

// File: rtl/stp_channel_ifs.sv
// Valid/ready channel interfaces for the request and response items.
interface stp_req_if #(
   parameter int ADC_BITS = stp_pkg::ADC_BITS_DEFAULT
);
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] adc_sample;
   logic                home_request;
   logic                run_request;

   modport source (output valid, output adc_sample, output home_request,
                   output run_request, input ready);
   modport sink   (input valid, input adc_sample, input home_request,
                   input run_request, output ready);
endinterface

interface stp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic        [stp_pkg::PHASE_W-1:0] coil_phase;
   logic signed [stp_pkg::POS_W-1:0]   position;
   logic        [stp_pkg::LEVEL_W-1:0] light_level;
   logic                               sweep_end;
   logic        [stp_pkg::LEVEL_W-1:0] peak_level;
   logic signed [stp_pkg::POS_W-1:0]   peak_position;

   modport source (output valid, output coil_phase, output position,
                   output light_level, output sweep_end, output peak_level,
                   output peak_position, input ready);
   modport sink   (input valid, input coil_phase, input position,
                   input light_level, input sweep_end, input peak_level,
                   input peak_position, output ready);
endinterface

// File: rtl/stepper_sweep_light_peak_tracker.sv
// Top level of the stepper sweep light peak tracker.
//
// One request item per tick: adc_sample, home_request, run_request. One
// response item per request: coil_phase, position, light_level, sweep_end,
// peak_level, peak_position. Both channels are valid/ready; an item moves
// at a rising clock edge with valid and ready high.
// csr_wr_en/csr_wr_data write sweep_limit (reset 50); write it only idle.
// An accepted item is divided in the restoring divider (ADC_BITS+7
// quotient bits, one quotient bit per cycle), then committed once the
// response register is free; the commit loads it and raises response valid.
// No new item is accepted until the previous one is committed;
// request ready rises again right after the commit cycle.
// The response register decouples the sides: a new item is accepted and
// divided while the previous response still waits. If the receiver stalls
// longer, the finished item waits in the commit state until it drains.
// Reset (synchronous, active high) puts the motor at step 1 moving up,
// sweeping, clears the peak and drops any pending response.
`include "assert_macros.svh"

module stepper_sweep_light_peak_tracker #(
   parameter int ADC_BITS = stp_pkg::ADC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   stp_req_if.sink                     req_chan,
   stp_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [stp_pkg::LIMIT_W-1:0] csr_wr_data
);
   stp_pkg::dp_cmd_type    cmd;
   stp_pkg::dp_status_type status;

   // sequence each item: capture, divide, commit
   stp_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // hold the divider, tracker state and response register
   stp_datapath #(
      .ADC_BITS (ADC_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .adc_sample    (req_chan.adc_sample),
      .home_request  (req_chan.home_request),
      .run_request   (req_chan.run_request),
      .coil_phase    (rsp_chan.coil_phase),
      .position      (rsp_chan.position),
      .light_level   (rsp_chan.light_level),
      .sweep_end     (rsp_chan.sweep_end),
      .peak_level    (rsp_chan.peak_level),
      .peak_position (rsp_chan.peak_position)
   );

   // drop ready for the whole division after an item is taken
   `STP_ASSERT(a_busy_after_accept, clock, reset,
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
   // commit never overwrites a response still waiting
   `STP_NEVER(a_no_overwrite, clock, reset,
      cmd.commit && rsp_chan.valid && !rsp_chan.ready)
   // peak fields are zero outside a sweep end
   `STP_ASSERT(a_peak_zero, clock, reset,
      (rsp_chan.valid && !rsp_chan.sweep_end) |->
         (rsp_chan.peak_level == '0 && rsp_chan.peak_position == '0))
   // coil drive is always a single phase
   `STP_ASSERT(a_phase_onehot, clock, reset,
      rsp_chan.valid |-> $onehot(rsp_chan.coil_phase))
endmodule

// File: rtl/stp_datapath.sv
// Datapath: serial light level divider, sweep tracker and result register.
module stp_datapath #(
   parameter int ADC_BITS = stp_pkg::ADC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  stp_pkg::dp_cmd_type                cmd,
   output stp_pkg::dp_status_type             status,
   input  logic                               csr_wr_en,
   input  logic        [stp_pkg::LIMIT_W-1:0] csr_wr_data,
   input  logic        [ADC_BITS-1:0]         adc_sample,
   input  logic                               home_request,
   input  logic                               run_request,
   output logic        [stp_pkg::PHASE_W-1:0] coil_phase,
   output logic signed [stp_pkg::POS_W-1:0]   position,
   output logic        [stp_pkg::LEVEL_W-1:0] light_level,
   output logic                               sweep_end,
   output logic        [stp_pkg::LEVEL_W-1:0] peak_level,
   output logic signed [stp_pkg::POS_W-1:0]   peak_position
);
   localparam int NUM_W  = ADC_BITS + 7;
   localparam int WIDE_W = (NUM_W > stp_pkg::LEVEL_W) ? NUM_W : stp_pkg::LEVEL_W;
   localparam int CNT_W  = $clog2(NUM_W);
   localparam logic [ADC_BITS-1:0] FULL = ADC_BITS'((2 ** ADC_BITS) - 1);
   localparam logic [stp_pkg::LEVEL_W-1:0] SAT_LEVEL =
      stp_pkg::LEVEL_W'(((2 ** ADC_BITS) - 1) * stp_pkg::LEVEL_SCALE);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

   // item capture and divider
   logic [ADC_BITS-1:0] samp_ff;
   logic                home_ff, run_ff;
   logic [ADC_BITS-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ADC_BITS:0]   trial, diff;
   logic [ADC_BITS-1:0] numer_base;
   logic                qbit;

   // tracker state
   logic        [stp_pkg::LIMIT_W-1:0] limit_ff;
   logic signed [stp_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                               up_ff, up_in;
   logic                               park_ff, park_in;
   logic        [stp_pkg::LEVEL_W-1:0] best_ff, best_in;
   logic signed [stp_pkg::POS_W-1:0]   bpos_ff, bpos_in;

   logic        [WIDE_W-1:0]           quo_wide;
   logic        [stp_pkg::LEVEL_W-1:0] level, best_upd;
   logic signed [stp_pkg::POS_W-1:0]   lim_pos, lim_neg;
   logic                               at_end;

   // result register
   logic        [stp_pkg::PHASE_W-1:0] phase_ff;
   logic signed [stp_pkg::POS_W-1:0]   rpos_ff;
   logic        [stp_pkg::LEVEL_W-1:0] level_ff;
   logic                               end_ff;
   logic        [stp_pkg::LEVEL_W-1:0] peak_ff;
   logic signed [stp_pkg::POS_W-1:0]   ppos_ff;

   assign numer_base = FULL - adc_sample;
   assign trial      = {rem_ff, quo_ff[NUM_W-1]};
   assign diff       = trial - {1'b0, samp_ff};
   assign qbit       = (trial >= {1'b0, samp_ff});

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         rem_in = '0;
         quo_in = NUM_W'(numer_base) * NUM_W'(stp_pkg::LEVEL_SCALE);
         cnt_in = '0;
      end else if (cmd.shift) begin
         rem_in = qbit ? diff[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
         quo_in = {quo_ff[NUM_W-2:0], qbit};
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   assign status.div_last = (cnt_ff == CNT_LAST);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         samp_ff <= adc_sample;
         home_ff <= home_request;
         run_ff  <= run_request;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   // light level, masked to the field width; zero sample saturates
   assign quo_wide = WIDE_W'(quo_ff);
   assign level    = (samp_ff == '0) ? SAT_LEVEL : quo_wide[stp_pkg::LEVEL_W-1:0];

   assign lim_pos = signed'({1'b0, limit_ff});
   assign lim_neg = -lim_pos;

   always_comb begin
      park_in  = run_ff ? 1'b0 : (home_ff ? 1'b1 : park_ff);
      best_upd = best_ff;
      bpos_in  = bpos_ff;
      if (best_ff < level) begin
         best_upd = level;
         bpos_in  = pos_ff;
      end
      at_end  = (pos_ff >= lim_pos) || (pos_ff <= lim_neg);
      up_in   = at_end ? !up_ff : up_ff;
      best_in = at_end ? '0 : best_upd;
      pos_in  = pos_ff;
      if (!(park_in && (pos_ff == '0))) begin
         pos_in = up_in ? pos_ff + 8'sd1 : pos_ff - 8'sd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= stp_pkg::LIMIT_RESET;
         pos_ff   <= signed'(stp_pkg::POS_RESET);
         up_ff    <= 1'b1;
         park_ff  <= 1'b0;
         best_ff  <= '0;
         bpos_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            pos_ff  <= pos_in;
            up_ff   <= up_in;
            park_ff <= park_in;
            best_ff <= best_in;
            bpos_ff <= bpos_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         phase_ff <= stp_pkg::phase_of(pos_in[1:0]);
         rpos_ff  <= pos_in;
         level_ff <= level;
         end_ff   <= at_end;
         peak_ff  <= at_end ? best_upd : '0;
         ppos_ff  <= at_end ? bpos_in : '0;
      end
   end

   assign coil_phase    = phase_ff;
   assign position      = rpos_ff;
   assign light_level   = level_ff;
   assign sweep_end     = end_ff;
   assign peak_level    = peak_ff;
   assign peak_position = ppos_ff;
endmodule

// File: rtl/stp_controller.sv
// Controller: sequences capture, division steps and commit of each item.
module stp_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output stp_pkg::dp_cmd_type    cmd,
   input  stp_pkg::dp_status_type status
);
   stp_pkg::ctl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stp_pkg::ST_IDLE:   if (req_valid)       state_in = stp_pkg::ST_CALC;
         stp_pkg::ST_CALC:   if (status.div_last) state_in = stp_pkg::ST_FINISH;
         stp_pkg::ST_FINISH: if (out_free)        state_in = stp_pkg::ST_IDLE;
         default:            state_in = stp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.shift  = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         stp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         stp_pkg::ST_CALC:   cmd.shift  = 1'b1;
         stp_pkg::ST_FINISH: cmd.commit = out_free;
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
